// File: hdl/rar_pkg.sv
// Package: widths, word types and opcodes for the rational arithmetic unit.
`default_nettype none
package rar_pkg;
  localparam int OperandWidth = 16;
  localparam int ProdWidth = 2 * OperandWidth;
  localparam int SumWidth = ProdWidth + 1;
  localparam int MagWidth = SumWidth;
  localparam int NumOutWidth = 33;
  localparam int DenOutWidth = 31;
  localparam int CntWidth = $clog2(MagWidth + 2);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic signed [OperandWidth-1:0] a_num;
    logic signed [OperandWidth-1:0] a_den;
    logic signed [OperandWidth-1:0] b_num;
    logic signed [OperandWidth-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [NumOutWidth-1:0] res_num;
    logic [DenOutWidth-1:0] res_den;
    logic zero_den_error;
  } out_word_t;

  // Classified job passed from front to back.
  typedef struct packed {
    logic [MagWidth-1:0] nm;
    logic [MagWidth-1:0] dm;
    logic neg;
    logic zero_den;
    logic zero_num;
  } job_t;
endpackage
`default_nettype wire

// File: hdl/rar_front.sv
// Front end: registers the cross products, then classifies the result.
`default_nettype none
module rar_front import rar_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          job_valid,
  input  wire logic     job_stall,
  output job_t          job
);
  logic busy;
  logic phase;
  in_word_t hold;
  logic signed [ProdWidth-1:0] p0, p1, p2;
  logic signed [ProdWidth-1:0] m0, m1, m2;
  logic signed [SumWidth-1:0] n_sum;
  logic signed [ProdWidth-1:0] d_prod;

  assign in_stall = busy;

  always_comb begin
    m0 = ProdWidth'(hold.a_num * hold.b_den);
    m1 = ProdWidth'(hold.b_num * hold.a_den);
    m2 = ProdWidth'(hold.a_num * hold.b_num);
  end

  always_comb begin
    case (hold.opcode)
      OP_ADD:  n_sum = SumWidth'(p0) + SumWidth'(p1);
      OP_SUB:  n_sum = SumWidth'(p0) - SumWidth'(p1);
      OP_MUL:  n_sum = SumWidth'(p2);
      default: n_sum = SumWidth'(p0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= 1'b0;
    end else if (!busy) begin
      if (in_valid) begin
        hold <= in_word;
        busy <= 1'b1;
        phase <= 1'b0;
      end
    end else if (!phase) begin
      p0 <= m0;
      p1 <= m1;
      p2 <= m2;
      // denominator product goes to d_prod in the always_ff below
      phase <= 1'b1;
    end else if (!job_valid || !job_stall) begin
      job.zero_den <= (d_prod == '0);
      job.zero_num <= (n_sum == '0);
      job.neg <= n_sum[SumWidth-1] ^ d_prod[ProdWidth-1];
      job.nm <= n_sum[SumWidth-1] ? MagWidth'(-n_sum) : MagWidth'(n_sum);
      job.dm <= d_prod[ProdWidth-1] ? MagWidth'(-SumWidth'(d_prod))
                                    : MagWidth'(d_prod);
      busy <= 1'b0;
    end
  end

  // Word valid: set when a job is handed over, cleared once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (busy && phase && (!job_valid || !job_stall)) begin
      job_valid <= 1'b1;
    end else if (job_valid && !job_stall) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !phase) begin
      d_prod <= (hold.opcode == OP_DIV) ? ProdWidth'(hold.a_den * hold.b_num)
                                        : ProdWidth'(hold.a_den * hold.b_den);
    end
  end
endmodule
`default_nettype wire

// File: hdl/rar_queue.sv
// Two-entry word queue between front and back.
`default_nettype none
module rar_queue import rar_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_stall,
  input  wire job_t wr_job,
  output logic      rd_valid,
  input  wire logic rd_stall,
  output job_t      rd_job
);
  job_t slot [2];
  logic wp, rp;
  logic [1:0] fill;
  logic push, pop;

  assign wr_stall = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_job = slot[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= wr_job;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// File: hdl/rar_back.sv
// Back end: binary GCD, then two restoring divisions by the GCD.
`default_nettype none
module rar_back import rar_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic      job_stall,
  input  wire job_t job,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0] state;
  logic [MagWidth-1:0] u, v, nm, dm, g;
  logic [CntWidth-1:0] shift;
  logic [CntWidth-1:0] cnt;
  logic [MagWidth-1:0] qn, qd;
  logic [MagWidth:0] rn, rdm;
  logic neg;
  logic [MagWidth:0] rn_try, rd_try;
  logic [MagWidth-1:0] diff;
  out_word_t res;

  assign job_stall = (state != S_IDLE);
  assign rn_try = {rn[MagWidth-1:0], qn[MagWidth-1]} - {1'b0, g};
  assign rd_try = {rdm[MagWidth-1:0], qd[MagWidth-1]} - {1'b0, g};
  assign diff = (u > v) ? u - v : v - u;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (job_valid) begin
          nm <= job.nm;
          dm <= job.dm;
          u <= job.nm;
          v <= job.dm;
          neg <= job.neg;
          shift <= '0;
          if (job.zero_den || job.zero_num) begin
            res.res_num <= '0;
            res.res_den <= job.zero_den ? '0 : DenOutWidth'(1);
            res.zero_den_error <= job.zero_den;
            state <= S_OUT;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (u == v) begin
            g <= u << shift;
            qn <= nm;
            qd <= dm;
            rn <= '0;
            rdm <= '0;
            cnt <= '0;
            state <= S_DIV;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            shift <= shift + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= diff >> 1;
          end else begin
            v <= diff >> 1;
          end
        end
        S_DIV: begin
          if (!rn_try[MagWidth]) begin
            rn <= rn_try;
            qn <= {qn[MagWidth-2:0], 1'b1};
          end else begin
            rn <= {rn[MagWidth-1:0], qn[MagWidth-1]};
            qn <= {qn[MagWidth-2:0], 1'b0};
          end
          if (!rd_try[MagWidth]) begin
            rdm <= rd_try;
            qd <= {qd[MagWidth-2:0], 1'b1};
          end else begin
            rdm <= {rdm[MagWidth-1:0], qd[MagWidth-1]};
            qd <= {qd[MagWidth-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CntWidth'(MagWidth - 1)) state <= S_LOAD;
        end
        S_LOAD: begin
          res.res_num <= neg ? NumOutWidth'(-qn) : NumOutWidth'(qn);
          res.res_den <= DenOutWidth'(qd);
          res.zero_den_error <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_word <= res;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output valid: raised with a new word, dropped once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: hdl/rational_arith_reduce_unit.sv
// Top level: rational add/sub/mul/div with GCD reduction.
//
//   channel | dir | payload    | handshake
//   in      | in  | in_word_t  | in_valid / in_stall
//   out     | out | out_word_t | out_valid / out_stall
//
// Front end steps per word: capture, multiply, classify; in_stall while busy.
// Back end: accept, binary GCD, 33 division steps for numerator and
// denominator together, load and output; zero cases skip straight to
// output. The back end takes a new word only once it is back in idle.
// Synchronous reset clears all control; a stalled output holds its word,
// and a two-word queue lets the front take the next word meanwhile.
`default_nettype none
module rational_arith_reduce_unit import rar_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);
  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  rar_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );
  rar_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_job(q_job)
  );
  rar_back u_back (
    .clk, .rst, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .out_valid, .out_stall, .out_word
  );
endmodule
`default_nettype wire
